@@ design/nmea_gga_field_parser_defines.svh @@
// ----------------------------------------------------------------------------
// NMEA GGA field parser assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_FIELD_PARSER_DEFINES_SVH
`define NMEA_GGA_FIELD_PARSER_DEFINES_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define NGGA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication checked at every clock edge outside reset.
`define NGGA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// An implication whose consequent is checked in the cycle after the antecedent.
`define NGGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NGGA_ASSERT(label, clk, rst_n, prop, msg)
`define NGGA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define NGGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/ngga_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA parser package
// Character codes, queue sizing and the record passed from front to back.
// ----------------------------------------------------------------------------
package ngga_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [5:0] hhmmss_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] byte_offset;
    logic [4:0] field_number;
    logic       is_field_end;
    logic [6:0] field_start;
    logic       time_valid;
    hhmmss_t    time_digits;
    logic       overflow;
  } item_t;

endpackage

@@ design/ngga_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA front end
// Watches for the GGA tag, tracks offsets, fields and the hhmmss digits, and
// hands one record per captured byte to the queue.
// ----------------------------------------------------------------------------
module ngga_front #(
  parameter int BUFFER_DEPTH = 128,
  parameter int COMMA_SLOTS  = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output ngga_pkg::item_t item
);

  localparam int BCW = $clog2(BUFFER_DEPTH + 1);
  localparam int CCW = $clog2(COMMA_SLOTS + 1);

  logic [2:0][7:0]     window_r, window_nxt;
  logic                capturing_r, capturing_nxt;
  logic [BCW-1:0]      byte_count_r, byte_count_nxt;
  logic [CCW-1:0]      comma_count_r, comma_count_nxt;
  logic [6:0]          field_start_r, field_start_nxt;
  ngga_pkg::hhmmss_t   digits_r, digits_nxt;
  logic                closed_r, closed_nxt;
  logic                overflow_r, overflow_nxt;

  logic [BCW+6:0]      offset_ext;
  logic [CCW+4:0]      field_ext;
  logic                is_digit;
  logic                tag_seen;
  logic                comma_room;

  assign offset_ext = {7'd0, byte_count_r};
  assign field_ext  = {5'd0, comma_count_r};
  assign tag_seen   = (window_r[0] == ngga_pkg::CHAR_G) && (window_r[1] == ngga_pkg::CHAR_G) &&
                      (window_r[2] == ngga_pkg::CHAR_A);
  assign comma_room = (comma_count_r < CCW'(COMMA_SLOTS));

  always_comb begin
    is_digit = rx_byte inside {[ngga_pkg::CHAR_ZERO:ngga_pkg::CHAR_NINE]};
  end

  always_comb begin
    window_nxt      = window_r;
    capturing_nxt   = capturing_r;
    byte_count_nxt  = byte_count_r;
    comma_count_nxt = comma_count_r;
    field_start_nxt = field_start_r;
    digits_nxt      = digits_r;
    closed_nxt      = closed_r;
    overflow_nxt    = overflow_r;
    push            = 1'b0;

    item.data_byte    = rx_byte;
    item.byte_offset  = offset_ext[6:0];
    item.field_number = field_ext[4:0];
    item.is_field_end = 1'b0;
    item.field_start  = field_start_r;
    item.time_valid   = 1'b0;
    item.time_digits  = digits_r;
    item.overflow     = overflow_r;

    if (take) begin
      if (rx_byte == ngga_pkg::CHAR_DOLLAR || (!capturing_r && tag_seen)) begin
        // A new sentence, or the byte after the tag: restart the offset, field, digit and flag state.
        capturing_nxt   = !capturing_r && tag_seen && rx_byte != ngga_pkg::CHAR_DOLLAR;
        byte_count_nxt  = '0;
        comma_count_nxt = '0;
        field_start_nxt = '0;
        digits_nxt      = '0;
        closed_nxt      = 1'b0;
        overflow_nxt    = 1'b0;
        if (capturing_nxt) begin
          window_nxt = '0;
        end
      end else if (!capturing_r) begin
        window_nxt = {rx_byte, window_r[2], window_r[1]};
      end else if (byte_count_r >= BCW'(BUFFER_DEPTH)) begin
        overflow_nxt = 1'b1;
      end else begin
        push           = 1'b1;
        byte_count_nxt = byte_count_r + BCW'(1);
        if (comma_count_r == '0 && !closed_r) begin
          if (is_digit) begin
            // Once six digits are held with a nonzero top digit, any further digit saturates to 999999.
            if (digits_r[5] != 4'd0) begin
              digits_nxt = {6{4'd9}};
            end else begin
              digits_nxt = {digits_r[4:0], rx_byte[3:0]};
            end
          end else begin
            closed_nxt = 1'b1;
          end
        end
        if (rx_byte == ngga_pkg::CHAR_COMMA) begin
          if (!comma_room) begin
            overflow_nxt = 1'b1;
          end else begin
            item.is_field_end = 1'b1;
            item.time_valid   = (comma_count_r == '0);
            comma_count_nxt   = comma_count_r + CCW'(1);
            field_start_nxt   = offset_ext[6:0] + 7'd1;
          end
        end
        item.overflow = overflow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= '0;
      capturing_r   <= 1'b0;
      byte_count_r  <= '0;
      comma_count_r <= '0;
      field_start_r <= '0;
      digits_r      <= '0;
      closed_r      <= 1'b0;
      overflow_r    <= 1'b0;
    end else begin
      window_r      <= window_nxt;
      capturing_r   <= capturing_nxt;
      byte_count_r  <= byte_count_nxt;
      comma_count_r <= comma_count_nxt;
      field_start_r <= field_start_nxt;
      digits_r      <= digits_nxt;
      closed_r      <= closed_nxt;
      overflow_r    <= overflow_nxt;
    end
  end

endmodule

@@ design/ngga_queue.sv @@
`timescale 1ns / 1ps
`include "nmea_gga_field_parser_defines.svh"
// ----------------------------------------------------------------------------
// NMEA GGA record queue
// Small FIFO of parsed records between the front end and the output stage.
// ----------------------------------------------------------------------------
module ngga_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ngga_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output ngga_pkg::item_t pop_item,
  output logic            empty
);

  localparam int AW = ngga_pkg::QUEUE_AW;

  ngga_pkg::item_t entries_r [ngga_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(ngga_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `NGGA_ASSERT(a_count_bound, clk, rst_n, count_r <= (AW+1)'(ngga_pkg::QUEUE_DEPTH), "queue count exceeds depth")
  `NGGA_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from an empty queue")
  `NGGA_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + (AW+1)'(1), "count did not grow on push")
  `NGGA_ASSERT_IMPL(a_ptr_gap, clk, rst_n, !full && !empty, wr_ptr_r != rd_ptr_r, "pointers meet with a partly filled queue")

endmodule

@@ design/ngga_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA output stage
// Takes records from the queue, converts the hhmmss digits and holds the
// result request until the consumer takes it.
// ----------------------------------------------------------------------------
module ngga_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ngga_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_data_byte,
  output logic [6:0]      out_byte_offset,
  output logic [4:0]      out_field_number,
  output logic            out_is_field_end,
  output logic [6:0]      out_field_start,
  output logic            out_time_valid,
  output logic [6:0]      out_time_hours,
  output logic [6:0]      out_time_minutes,
  output logic [6:0]      out_time_seconds,
  output logic            out_overflow
);

  logic                 valid_r, valid_nxt;
  ngga_pkg::item_t      item_r;
  logic [6:0]           hours_r, minutes_r, seconds_r;

  function automatic logic [6:0] bcd_pair(input ngga_pkg::bcd_digit_t tens,
                                          input ngga_pkg::bcd_digit_t ones);
    bcd_pair = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
  endfunction

  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      if (q_item.time_valid) begin
        hours_r   <= bcd_pair(q_item.time_digits[5], q_item.time_digits[4]);
        minutes_r <= bcd_pair(q_item.time_digits[3], q_item.time_digits[2]);
        seconds_r <= bcd_pair(q_item.time_digits[1], q_item.time_digits[0]);
      end else begin
        hours_r   <= '0;
        minutes_r <= '0;
        seconds_r <= '0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_data_byte    = item_r.data_byte;
  assign out_byte_offset  = item_r.byte_offset;
  assign out_field_number = item_r.field_number;
  assign out_is_field_end = item_r.is_field_end;
  assign out_field_start  = item_r.field_start;
  assign out_time_valid   = item_r.time_valid;
  assign out_time_hours   = hours_r;
  assign out_time_minutes = minutes_r;
  assign out_time_seconds = seconds_r;
  assign out_overflow     = item_r.overflow;

endmodule

@@ design/nmea_gga_field_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA field parser
// Byte-serial GGA sentence capture with field tagging and UTC time decode.
// ----------------------------------------------------------------------------
// Accepts one received character per clock cycle for as long as the four-entry
// record queue has room; each captured byte leaves as one result request via
// the queue and output register, and a stalled consumer only stops input
// once the queue and output register are full. A '$' restarts the sentence,
// the tag GGA plus the byte after it start capture, and every later byte is
// reported with its offset, field number and field start until BUFFER_DEPTH
// bytes have been taken; the comma that closes field 0 carries hours, minutes
// and seconds decoded from the leading digits of that field.
module nmea_gga_field_parser #(
  parameter int BUFFER_DEPTH = 128,
  parameter int COMMA_SLOTS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [6:0] out_byte_offset,
  output logic [4:0] out_field_number,
  output logic       out_is_field_end,
  output logic [6:0] out_field_start,
  output logic       out_time_valid,
  output logic [6:0] out_time_hours,
  output logic [6:0] out_time_minutes,
  output logic [6:0] out_time_seconds,
  output logic       out_overflow
);

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  ngga_pkg::item_t front_item;
  ngga_pkg::item_t q_item;

  assign in_ready = !q_full;

  ngga_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .COMMA_SLOTS  (COMMA_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_valid && in_ready),
    .rx_byte (in_rx_byte),
    .push    (q_push),
    .item    (front_item)
  );

  ngga_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  ngga_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_byte_offset  (out_byte_offset),
    .out_field_number (out_field_number),
    .out_is_field_end (out_is_field_end),
    .out_field_start  (out_field_start),
    .out_time_valid   (out_time_valid),
    .out_time_hours   (out_time_hours),
    .out_time_minutes (out_time_minutes),
    .out_time_seconds (out_time_seconds),
    .out_overflow     (out_overflow)
  );

endmodule

@@ tb/sv/nmea_gga_field_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA GGA field parser testbench
// Streams GGA sentences, broken sentences and noise bytes into the parser and
// checks every captured byte record against a cycle-free model of the parser.
// The run passes through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module nmea_gga_field_parser_tb;
  import ngga_pkg::*;

  localparam int BUFFER_DEPTH = 128;
  localparam int COMMA_SLOTS  = 32;
  localparam int TARGET_BYTES = 1050;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 20;
  localparam int TIME_CAP     = 999999;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_TX_IDLE,
    PH_RX_STALL,
    PH_BOTH_IDLE
  } phase_e;

  typedef struct {
    logic [7:0] data;
    phase_e     phase;
    bit         hold;
  } rx_item_t;

  typedef struct {
    logic [7:0] data_byte;
    logic [6:0] byte_offset;
    logic [4:0] field_number;
    logic       is_field_end;
    logic [6:0] field_start;
    logic       time_valid;
    logic [6:0] time_hours;
    logic [6:0] time_minutes;
    logic [6:0] time_seconds;
    logic       overflow;
  } capture_rec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic [6:0] out_byte_offset;
  logic [4:0] out_field_number;
  logic       out_is_field_end;
  logic [6:0] out_field_start;
  logic       out_time_valid;
  logic [6:0] out_time_hours;
  logic [6:0] out_time_minutes;
  logic [6:0] out_time_seconds;
  logic       out_overflow;

  rx_item_t     rx_pending[$];
  capture_rec_t capture_expected[$];
  phase_e       tx_phase = PH_STEADY;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Parser model state.
  logic [7:0] tag_win [3] = '{8'h00, 8'h00, 8'h00};
  bit         capturing = 1'b0;
  int         byte_count = 0;
  int         comma_count = 0;
  int         field_start = 0;
  int         time_acc = 0;
  bit         digits_closed = 1'b0;
  bit         overflow_seen = 1'b0;

  nmea_gga_field_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .COMMA_SLOTS (COMMA_SLOTS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_byte_offset (out_byte_offset),
    .out_field_number(out_field_number),
    .out_is_field_end(out_is_field_end),
    .out_field_start (out_field_start),
    .out_time_valid  (out_time_valid),
    .out_time_hours  (out_time_hours),
    .out_time_minutes(out_time_minutes),
    .out_time_seconds(out_time_seconds),
    .out_overflow    (out_overflow)
  );

  always #5 clk = ~clk;

  function automatic void clear_sentence();
    capturing     = 1'b0;
    byte_count    = 0;
    comma_count   = 0;
    field_start   = 0;
    time_acc      = 0;
    digits_closed = 1'b0;
    overflow_seen = 1'b0;
  endfunction

  // Advances the parser model by one accepted byte and queues the record it
  // produces, if any.
  function automatic void predict_capture(logic [7:0] c);
    capture_rec_t rec;
    int offset;
    int next_acc;
    if (c == CHAR_DOLLAR) begin
      clear_sentence();
    end else if (!capturing) begin
      if (tag_win[0] == CHAR_G && tag_win[1] == CHAR_G && tag_win[2] == CHAR_A) begin
        tag_win = '{8'h00, 8'h00, 8'h00};
        clear_sentence();
        capturing = 1'b1;
      end else begin
        tag_win[0] = tag_win[1];
        tag_win[1] = tag_win[2];
        tag_win[2] = c;
      end
    end else if (byte_count >= BUFFER_DEPTH) begin
      overflow_seen = 1'b1;
    end else begin
      offset = byte_count;
      byte_count++;
      rec = '{default: '0};
      rec.data_byte    = c;
      rec.byte_offset  = 7'(offset);
      rec.field_number = 5'(comma_count);
      rec.field_start  = 7'(field_start);
      if (comma_count == 0 && !digits_closed) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          next_acc = time_acc * 10 + int'(c - CHAR_ZERO);
          time_acc = (next_acc > TIME_CAP) ? TIME_CAP : next_acc;
        end else begin
          digits_closed = 1'b1;
        end
      end
      if (c == CHAR_COMMA) begin
        if (comma_count >= COMMA_SLOTS) begin
          overflow_seen = 1'b1;
        end else begin
          rec.is_field_end = 1'b1;
          if (comma_count == 0) begin
            rec.time_valid   = 1'b1;
            rec.time_hours   = 7'(time_acc / 10000);
            rec.time_minutes = 7'((time_acc % 10000) / 100);
            rec.time_seconds = 7'(time_acc % 100);
          end
          comma_count++;
          field_start = offset + 1;
        end
      end
      rec.overflow = overflow_seen;
      capture_expected.push_back(rec);
    end
  endfunction

  function automatic bit pause_roll(phase_e ph, bit tx_side);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_TX_IDLE:   return tx_side && roll < 86;
      PH_RX_STALL:  return !tx_side && roll < 86;
      PH_BOTH_IDLE: return roll < 16;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic push_byte(logic [7:0] b);
    rx_item_t item;
    item.data  = b;
    item.phase = PH_STEADY;
    item.hold  = 1'b0;
    rx_pending.push_back(item);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) begin
      push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  function automatic logic [7:0] field_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return CHAR_ZERO + 8'($urandom_range(0, 9));
    else if (roll < 60) return ".";
    else if (roll < 90) return 8'h41 + 8'($urandom_range(0, 25));
    else return "-";
  endfunction

  task automatic push_header();
    string talker;
    case ($urandom_range(0, 3))
      0:       talker = "GP";
      1:       talker = "GN";
      2:       talker = "GL";
      default: talker = "GA";
    endcase
    push_byte(CHAR_DOLLAR);
    push_text(talker);
    push_text("GGA");
  endtask

  // A well-formed sentence with random time, fields and checksum.
  task automatic push_gga_sentence();
    int n_digits;
    int n_fields;
    int len;
    push_header();
    push_byte(CHAR_COMMA);
    n_digits = ($urandom_range(0, 99) < 70) ? 6 : $urandom_range(0, 9);
    push_digits(n_digits);
    if ($urandom_range(0, 1)) begin
      push_text(".");
      push_digits($urandom_range(0, 3));
    end
    push_byte(CHAR_COMMA);
    n_fields = $urandom_range(0, 14);
    for (int f = 0; f < n_fields; f++) begin
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        push_byte(field_char());
      end
      push_byte(CHAR_COMMA);
    end
    push_text("*");
    push_byte(8'h30 + 8'($urandom_range(0, 9)));
    push_byte(8'h41 + 8'($urandom_range(0, 5)));
    push_byte(8'h0D);
    push_byte(8'h0A);
  endtask

  // A sentence long enough to run past the buffer and the comma slots.
  task automatic push_long_sentence();
    int len;
    push_header();
    push_byte(CHAR_COMMA);
    len = $urandom_range(130, 160);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 40) push_byte(CHAR_COMMA);
      else push_byte(field_char());
    end
  endtask

  task automatic push_broken_sentence();
    case ($urandom_range(0, 3))
      0: begin
        // Dollar sign inside the tag; the window survives it.
        push_text("$GPGG$A,");
        push_digits(4);
        push_byte(CHAR_COMMA);
      end
      1: begin
        // The byte after the tag is a digit and gets swallowed.
        push_header();
        push_digits(7);
        push_text(",,");
      end
      2: begin
        push_text("$GPGXA,");
        push_digits(6);
        push_byte(CHAR_COMMA);
      end
      default: begin
        // Sentence cut short by a new one.
        push_header();
        push_byte(CHAR_COMMA);
        push_digits($urandom_range(1, 5));
        push_gga_sentence();
      end
    endcase
  endtask

  task automatic push_noise();
    int len;
    len = $urandom_range(5, 30);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Sender: runs the model on each accepted byte and presents the next one.
  always @(posedge clk) begin : drive
    rx_item_t item;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        predict_capture(in_rx_byte);
      end
      if (!in_valid || in_ready) begin
        if (rx_pending.size() > 0 &&
            !(rx_pending[0].hold && capture_expected.size() != 0) &&
            !pause_roll(rx_pending[0].phase, 1'b1)) begin
          item = rx_pending.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= item.data;
          tx_phase   <= item.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted record against the oldest prediction.
  always @(posedge clk) begin : watch
    capture_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (capture_expected.size() == 0) begin
          $error("unexpected record: data_byte %0d, byte_offset %0d",
                 out_data_byte, out_byte_offset);
          fail_count++;
        end else begin
          want = capture_expected.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("byte_offset", 8'(want.byte_offset), 8'(out_byte_offset));
          check_field("field_number", 8'(want.field_number), 8'(out_field_number));
          check_field("is_field_end", 8'(want.is_field_end), 8'(out_is_field_end));
          check_field("field_start", 8'(want.field_start), 8'(out_field_start));
          check_field("time_valid", 8'(want.time_valid), 8'(out_time_valid));
          check_field("time_hours", 8'(want.time_hours), 8'(out_time_hours));
          check_field("time_minutes", 8'(want.time_minutes), 8'(out_time_minutes));
          check_field("time_seconds", 8'(want.time_seconds), 8'(out_time_seconds));
          check_field("overflow", 8'(want.overflow), 8'(out_overflow));
        end
      end
      out_ready <= !pause_roll(tx_phase, 1'b0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int quarter;
    int roll;

    // Directed opening: extreme bytes, a tag split by a dollar sign, a
    // swallowed non-comma after the tag, a saturating time and field ends.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("GG$A;9999999.5,N,");
    push_text("$GPGGA,235959.9,,");

    while (rx_pending.size() < TARGET_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) push_gga_sentence();
      else if (roll < 78) push_long_sentence();
      else if (roll < 90) push_broken_sentence();
      else push_noise();
    end

    n = rx_pending.size();
    quarter = n / 4;
    for (int i = 0; i < n; i++) begin
      rx_pending[i].phase = phase_e'((i / quarter > 3) ? 3 : i / quarter);
      rx_pending[i].hold  = (i == quarter) || (i == quarter + quarter / 2) ||
                            (i == 2 * quarter) || (i == 3 * quarter);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sample between edges so the driver's updates for the edge have settled.
    while (rx_pending.size() > 0 || in_valid || capture_expected.size() > 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && capture_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ngga_pkg.sv
design/ngga_front.sv
design/ngga_queue.sv
design/ngga_back.sv
design/nmea_gga_field_parser.sv
tb/sv/nmea_gga_field_parser_tb.sv
